[hw/rtl/pht_pkg.sv]
// Shared types and constants of the pair hash table.
package pht_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int BODY_BITS_DEF = 16;

  localparam int OP_W     = 3;
  localparam int BODY_W   = 16;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // Golden-ratio multiplier of the home slot hash, split in 32-bit halves.
  localparam logic [31:0] HASH_MUL_HI = 32'h9E37_79B9;
  localparam logic [31:0] HASH_MUL_LO = 32'h7F4A_7C15;

  localparam logic [VALUE_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP     = 3'd0,
    OP_INSERT     = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_SET_VALUE  = 3'd3,
    OP_BEGIN_UPD  = 3'd4,
    OP_MARK_MOVED = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

[hw/rtl/pht_hash.sv]
// Home slot hash: iterative 32x32 multiplier; reciprocal modulo when CAPACITY is not 2**n.
module pht_hash #(
  parameter int CAPACITY = pht_pkg::CAPACITY_DEF,
  parameter int KEY_W    = 2 * pht_pkg::BODY_BITS_DEF,
  localparam int IDX_W   = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [IDX_W-1:0] slot
);

  localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  // Reciprocal of the capacity rounded down; the quotient estimate is short by at most one.
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / CAPACITY);
  localparam logic [31:0] CAP_V = 32'(CAPACITY);

  typedef enum logic [2:0] {
    H_IDLE = 3'b001,
    H_MUL  = 3'b010,
    H_RED  = 3'b100
  } hstate_t;

  hstate_t state_r, state_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [63:0]      key_r, key_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [31:0]      h_r, h_nxt;
  logic             done_r, done_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;

  logic [63+KEY_W:0] key_ext;
  logic [31:0]       op_a, op_b, hsum;
  logic [31:0]       diff, rs;

  assign key_ext = {64'b0, key};
  assign hsum    = acc_r + prod_r[31:0];
  assign diff    = h_r - prod_r[31:0];
  assign rs      = (diff >= CAP_V) ? diff - CAP_V : diff;

  // The multiplier is shared by the hash steps and the two reduction steps.
  always_comb begin
    if (state_r == H_RED) begin
      op_a = (step_r == 2'd0) ? h_r : prod_r[63:32];
      op_b = (step_r == 2'd0) ? RECIP : CAP_V;
    end else begin
      op_a = (step_r == 2'd2) ? key_r[63:32] : key_r[31:0];
      op_b = (step_r == 2'd1) ? pht_pkg::HASH_MUL_HI : pht_pkg::HASH_MUL_LO;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    key_nxt   = key_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    h_nxt     = h_r;
    done_nxt  = 1'b0;
    slot_nxt  = slot_r;
    case (state_r)
      H_IDLE: begin
        if (start) begin
          key_nxt   = key_ext[63:0];
          step_nxt  = 2'd0;
          state_nxt = H_MUL;
        end
      end
      H_MUL: begin
        prod_nxt = op_a * op_b;
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd1:    acc_nxt = prod_r[63:32];
          2'd2:    acc_nxt = hsum;
          2'd3: begin
            if (IS_POW2) begin
              slot_nxt  = hsum[IDX_W-1:0];
              done_nxt  = 1'b1;
              state_nxt = H_IDLE;
            end else begin
              h_nxt     = hsum;
              step_nxt  = 2'd0;
              state_nxt = H_RED;
            end
          end
          default: acc_nxt = acc_r;
        endcase
      end
      H_RED: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) begin
          slot_nxt  = rs[IDX_W-1:0];
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          prod_nxt = op_a * op_b;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    h_r    <= h_nxt;
    slot_r <= slot_nxt;
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule

[hw/rtl/pht_mem.sv]
// Slot store: one write port and one registered read port.
module pht_mem #(
  parameter int DEPTH  = pht_pkg::CAPACITY_DEF,
  parameter int DATA_W = 2 * pht_pkg::BODY_BITS_DEF + 34,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pair_hash_table_linear_probe_top.sv]
// Top level of the pair hash table: command sequencer, slot store and hash unit.
//
// A fixed-capacity open-addressing map keyed by an unordered pair of body ids.
// Commands arrive as transactions on the in_ channel: in_tuser carries the
// operation, in_tdata the two body ids and the value for set value. Every
// command yields exactly one transaction on the out_ channel with the status
// in out_tuser and the looked-up value, obsolete mark and entry count in
// out_tdata.
// Each command is worked on alone; in_tready is low until its result is
// registered. A pair command is accepted, then the hash unit finds its home
// slot (4 multiplier steps, plus 3 reduction steps when the capacity is not
// a power of two), then the slots are probed in turn from the home slot.
// A remove also repairs the cluster behind the freed slot: each following
// occupied slot is rehashed through the same unit and moved unless it stays.
// Begin update and mark moved walk the whole table, rewriting each slot.
// After reset the store is cleared one slot a cycle, while in_tready stays
// low. A result waits in the output register while out_tready is low; the
// next command may be accepted meanwhile and its own result is held back
// until the register is free.
module pair_hash_table_linear_probe_top #(
  parameter int CAPACITY  = pht_pkg::CAPACITY_DEF,
  parameter int BODY_BITS = pht_pkg::BODY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // body_a[15:0], body_b[31:16], new_value[63:32]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // stored_value[31:0], is_obsolete[32], entry_count[43:33]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int KEY_W   = 2 * BODY_BITS;
  localparam int K_LO    = 32;
  localparam int OBS_BIT = KEY_W + 32;
  localparam int VLD_BIT = KEY_W + 33;
  localparam int ENT_W   = KEY_W + 34;
  localparam int HALF    = (CAPACITY + 1) / 2;
  localparam int CNT_W   = $clog2(HALF + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  typedef enum logic [14:0] {
    S_CLR    = 15'h0001,
    S_IDLE   = 15'h0002,
    S_HASH   = 15'h0004,
    S_PRD    = 15'h0008,
    S_PCHK   = 15'h0010,
    S_RMCLR  = 15'h0020,
    S_RMRD   = 15'h0040,
    S_RMCHK  = 15'h0080,
    S_RMHASH = 15'h0100,
    S_RMMV1  = 15'h0200,
    S_RMMV2  = 15'h0400,
    S_SWRD   = 15'h0800,
    S_SWWR   = 15'h1000,
    S_FIN    = 15'h2000,
    S_SPARE  = 15'h4000
  } state_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;   // probe position, sweep position
  logic [IDX_W-1:0]     rpos_r, rpos_nxt; // hole being repaired
  logic [IDX_W-1:0]     tpos_r, tpos_nxt; // slot under test behind the hole
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [pht_pkg::OP_W-1:0] op_r, op_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [BODY_BITS-1:0] body_r, body_nxt;
  logic [31:0]          nval_r, nval_nxt;
  logic [ENT_W-1:0]     ent_r, ent_nxt;
  logic [1:0]           res_st_r, res_st_nxt;
  logic [31:0]          res_val_r, res_val_nxt;
  logic                 res_obs_r, res_obs_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_st_r, out_st_nxt;
  logic [31:0]          out_val_r, out_val_nxt;
  logic                 out_obs_r, out_obs_nxt;
  logic [10:0]          out_cnt_r, out_cnt_nxt;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  logic [ENT_W-1:0]     mem_wdata, mem_rdata;
  logic                 hash_start, hash_done;
  logic [KEY_W-1:0]     hash_key;
  logic [IDX_W-1:0]     hash_slot;

  logic [BODY_BITS+47:0] a_ext, b_ext;
  logic [BODY_BITS-1:0]  body_a, body_b;
  logic [KEY_W-1:0]      in_key;
  logic [KEY_W-1:0]      rd_key;
  logic [BODY_BITS-1:0]  rd_lo, rd_hi;
  logic                  rd_valid, rd_match, stays;
  logic [CNT_W+10:0]     cnt_ext;

  assign a_ext  = {{BODY_BITS{1'b0}}, 32'b0, in_tdata[15:0]};
  assign b_ext  = {{BODY_BITS{1'b0}}, 32'b0, in_tdata[31:16]};
  assign body_a = a_ext[BODY_BITS-1:0];
  assign body_b = b_ext[BODY_BITS-1:0];
  assign in_key = (body_a < body_b) ? {body_b, body_a} : {body_a, body_b};

  assign rd_key   = mem_rdata[K_LO+KEY_W-1:K_LO];
  assign rd_lo    = rd_key[BODY_BITS-1:0];
  assign rd_hi    = rd_key[KEY_W-1:BODY_BITS];
  assign rd_valid = mem_rdata[VLD_BIT];
  assign rd_match = rd_valid && (rd_key == key_r);
  assign cnt_ext  = {11'b0, count_r};

  // An entry stays put when its home slot lies cyclically in (hole, tested slot].
  always_comb begin
    if (rpos_r <= tpos_r) begin
      stays = (rpos_r < hash_slot) && (hash_slot <= tpos_r);
    end else begin
      stays = (hash_slot <= tpos_r) || (hash_slot > rpos_r);
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rpos_nxt      = rpos_r;
    tpos_nxt      = tpos_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    body_nxt      = body_r;
    nval_nxt      = nval_r;
    ent_nxt       = ent_r;
    res_st_nxt    = res_st_r;
    res_val_nxt   = res_val_r;
    res_obs_nxt   = res_obs_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_val_nxt   = out_val_r;
    out_obs_nxt   = out_obs_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '0;
    mem_raddr     = idx_r;
    hash_start    = 1'b0;
    hash_key      = key_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = in_tuser;
          key_nxt     = in_key;
          body_nxt    = body_a;
          nval_nxt    = in_tdata[63:32];
          res_st_nxt  = pht_pkg::ST_DONE;
          res_val_nxt = '0;
          res_obs_nxt = 1'b0;
          idx_nxt     = '0;
          case (in_tuser)
            pht_pkg::OP_LOOKUP, pht_pkg::OP_INSERT,
            pht_pkg::OP_REMOVE, pht_pkg::OP_SET_VALUE: begin
              hash_start = 1'b1;
              hash_key   = in_key;
              state_nxt  = S_HASH;
            end
            pht_pkg::OP_BEGIN_UPD, pht_pkg::OP_MARK_MOVED: state_nxt = S_SWRD;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_nxt   = hash_slot;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        mem_waddr = idx_r;
        if (rd_match) begin
          state_nxt = S_FIN;
          case (op_r)
            pht_pkg::OP_LOOKUP: begin
              res_val_nxt = mem_rdata[31:0];
              res_obs_nxt = mem_rdata[OBS_BIT];
            end
            pht_pkg::OP_INSERT: begin
              mem_we             = 1'b1;
              mem_wdata          = mem_rdata;
              mem_wdata[OBS_BIT] = 1'b0;
              res_st_nxt         = pht_pkg::ST_PRESENT;
            end
            pht_pkg::OP_SET_VALUE: begin
              mem_we          = 1'b1;
              mem_wdata       = mem_rdata;
              mem_wdata[31:0] = nval_r;
            end
            default: begin
              rpos_nxt  = idx_r;
              state_nxt = S_RMCLR;
            end
          endcase
        end else if (!rd_valid) begin
          state_nxt = S_FIN;
          if (op_r == pht_pkg::OP_INSERT) begin
            if (count_r >= CNT_W'(HALF)) begin
              res_st_nxt = pht_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, 1'b0, key_r, pht_pkg::EMPTY_VALUE};
              count_nxt = count_r + 1'b1;
            end
          end else begin
            res_st_nxt = pht_pkg::ST_NOT_FOUND;
          end
        end else begin
          idx_nxt   = next_slot(idx_r);
          mem_raddr = next_slot(idx_r);
        end
      end
      S_RMCLR: begin
        mem_we    = 1'b1;
        mem_waddr = rpos_r;
        count_nxt = count_r - 1'b1;
        tpos_nxt  = next_slot(rpos_r);
        state_nxt = S_RMRD;
      end
      S_RMRD: begin
        mem_raddr = tpos_r;
        state_nxt = S_RMCHK;
      end
      S_RMCHK: begin
        if (!rd_valid) begin
          state_nxt = S_FIN;
        end else begin
          ent_nxt    = mem_rdata;
          hash_start = 1'b1;
          hash_key   = rd_key;
          state_nxt  = S_RMHASH;
        end
      end
      S_RMHASH: begin
        if (hash_done) begin
          if (stays) begin
            tpos_nxt  = next_slot(tpos_r);
            state_nxt = S_RMRD;
          end else begin
            state_nxt = S_RMMV1;
          end
        end
      end
      S_RMMV1: begin
        mem_we    = 1'b1;
        mem_waddr = rpos_r;
        mem_wdata = ent_r;
        state_nxt = S_RMMV2;
      end
      S_RMMV2: begin
        mem_we    = 1'b1;
        mem_waddr = tpos_r;
        rpos_nxt  = tpos_r;
        tpos_nxt  = next_slot(tpos_r);
        state_nxt = S_RMRD;
      end
      S_SWRD: begin
        state_nxt = S_SWWR;
      end
      S_SWWR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (op_r == pht_pkg::OP_BEGIN_UPD) begin
          mem_wdata[OBS_BIT] = 1'b0;
        end else if (rd_valid && (rd_lo == body_r || rd_hi == body_r)) begin
          mem_wdata[OBS_BIT] = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          mem_raddr = idx_r + 1'b1;
          state_nxt = S_SWRD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_val_nxt   = res_val_r;
          out_obs_nxt   = res_obs_r;
          out_cnt_nxt   = cnt_ext[10:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rpos_r    <= rpos_nxt;
    tpos_r    <= tpos_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    body_r    <= body_nxt;
    nval_r    <= nval_nxt;
    ent_r     <= ent_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    res_obs_r <= res_obs_nxt;
    out_st_r  <= out_st_nxt;
    out_val_r <= out_val_nxt;
    out_obs_r <= out_obs_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  pht_mem #(
    .DEPTH  (CAPACITY),
    .DATA_W (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pht_hash #(
    .CAPACITY (CAPACITY),
    .KEY_W    (KEY_W)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (hash_key),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {4'b0, out_cnt_r, out_obs_r, out_val_r};

  // The table never holds more than half its capacity, rounded up.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HALF))
    else $error("entry count above half capacity");

  // The hash unit only reports while the sequencer waits for it.
  a_hash_done: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == S_HASH || state_r == S_RMHASH))
    else $error("hash result while not waiting");

  // No store write happens while the block waits for a command.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  // A new result is only ever loaded from the finishing step.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finishing step");

endmodule

[tb/tb_pair_hash_table_linear_probe_top.sv]
// Self-checking testbench of the pair hash table: a table model predicts every command's result.
module tb_pair_hash_table_linear_probe_top;

  localparam int CAP       = 1024;
  localparam int N_FILL    = 60;
  localparam int N_RANDOM  = 342;
  localparam int WDOG_MAX  = 200000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic        obsolete;
    logic [10:0] count;
  } pair_result_t;

  // Behavioral copy of the table, kept by the test bench alongside the block.
  class pair_scoreboard;
    logic [31:0] keys [CAP];
    logic        valid [CAP];
    logic [31:0] vals [CAP];
    logic        obs [CAP];
    int unsigned count;
    pair_result_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < CAP; i++) begin
        keys[i] = '0; valid[i] = 1'b0; vals[i] = '0; obs[i] = 1'b0;
      end
      count = 0;
      errors = 0;
    endfunction

    function logic [31:0] make_key(logic [15:0] a, logic [15:0] b);
      logic [15:0] lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return {hi, lo};
    endfunction

    function int unsigned home_of(logic [31:0] k);
      logic [63:0] prod;
      prod = {32'd0, k} * 64'h9E37_79B9_7F4A_7C15;
      return prod[63:32] % CAP;
    endfunction

    // Returns the slot that holds the key, or the first free one on its run.
    function int unsigned find_slot(logic [31:0] k, output bit hit);
      int unsigned i;
      i = home_of(k);
      hit = 0;
      for (int n = 0; n < CAP; n++) begin
        if (!valid[i]) return i;
        if (keys[i] == k) begin
          hit = 1;
          return i;
        end
        i = (i + 1) % CAP;
      end
      return i;
    endfunction

    function void drop_at(int unsigned r);
      int unsigned t, f;
      bit stays;
      t = r;
      valid[r] = 0; keys[r] = '0;
      count--;
      for (int n = 0; n < CAP; n++) begin
        t = (t + 1) % CAP;
        if (!valid[t]) break;
        f = home_of(keys[t]);
        if (r <= t) stays = (r < f) && (f <= t);
        else stays = (f <= t) || (f > r);
        if (!stays) begin
          keys[r] = keys[t]; vals[r] = vals[t]; obs[r] = obs[t]; valid[r] = 1;
          valid[t] = 0; keys[t] = '0;
          r = t;
        end
      end
    endfunction

    function void note_command(logic [2:0] op, logic [15:0] a, logic [15:0] b,
                               logic [31:0] nv);
      pair_result_t r;
      logic [31:0] k;
      int unsigned i;
      bit hit;
      r = '0;
      k = make_key(a, b);
      case (op)
        pht_pkg::OP_LOOKUP: begin
          i = find_slot(k, hit);
          if (hit) begin
            r.value = vals[i]; r.obsolete = obs[i];
          end else r.status = pht_pkg::ST_NOT_FOUND;
        end
        pht_pkg::OP_INSERT: begin
          i = find_slot(k, hit);
          if (hit) begin
            obs[i] = 0; r.status = pht_pkg::ST_PRESENT;
          end else if (count * 2 >= CAP) r.status = pht_pkg::ST_FULL;
          else begin
            keys[i] = k; vals[i] = pht_pkg::EMPTY_VALUE; obs[i] = 0; valid[i] = 1;
            count++;
          end
        end
        pht_pkg::OP_REMOVE: begin
          i = find_slot(k, hit);
          if (hit) drop_at(i);
          else r.status = pht_pkg::ST_NOT_FOUND;
        end
        pht_pkg::OP_SET_VALUE: begin
          i = find_slot(k, hit);
          if (hit) vals[i] = nv;
          else r.status = pht_pkg::ST_NOT_FOUND;
        end
        pht_pkg::OP_BEGIN_UPD: for (int j = 0; j < CAP; j++) obs[j] = 0;
        pht_pkg::OP_MARK_MOVED:
          for (int j = 0; j < CAP; j++)
            if (valid[j] && (keys[j][15:0] == a || keys[j][31:16] == a)) obs[j] = 1;
        default: ;
      endcase
      r.count = count[10:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [47:0] d);
      pair_result_t e;
      if (pending.size() == 0) begin
        $error("result without a pending command");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status expected %0d actual %0d", e.status, st); errors++;
      end
      if (d[31:0] !== e.value) begin
        $error("stored_value expected %h actual %h", e.value, d[31:0]); errors++;
      end
      if (d[32] !== e.obsolete) begin
        $error("is_obsolete expected %0d actual %0d", e.obsolete, d[32]); errors++;
      end
      if (d[43:33] !== e.count) begin
        $error("entry_count expected %0d actual %0d", e.count, d[43:33]); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  pair_scoreboard sb = new();
  bit hold_off = 0;
  int idle_cycles = 0;
  logic [15:0] ids [16];

  pair_hash_table_linear_probe_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // One command: optional gap, offer it, hold until the handshake.
  // in_tvalid stays high after the handshake so a back-to-back command follows directly.
  task automatic send_cmd(logic [2:0] op, logic [15:0] a, logic [15:0] b, logic [31:0] nv,
                          bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {nv, b, a};
    do @(posedge clk); while (!in_tready);
    sb.note_command(op, a, b, nv);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : ids[$urandom_range(0, 15)];
  endfunction

  // Result side: a random wait before each result, plus one long hold-off that backs
  // the block up.
  initial begin
    int w;
    wait (rst_n === 1'b1);
    forever begin
      w = $urandom_range(0, 7);
      if (w > 0 || hold_off) begin
        out_tready <= 1'b0;
        repeat (w) @(negedge clk);
        while (hold_off) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata);
  end

  // Watchdog: the reset-time clear sweep and full-table walks fit well below the limit.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int sel;
    logic [15:0] a, b;
    for (int i = 0; i < 16; i++) ids[i] = 16'($urandom);
    ids[0] = 16'h0000;
    ids[1] = 16'hFFFF;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed commands: extreme ids, the zero pair, every operation, and the done, not-found and present statuses.
    send_cmd(pht_pkg::OP_LOOKUP, 16'h0000, 16'h0000, '0, 0);
    send_cmd(pht_pkg::OP_INSERT, 16'h0000, 16'h0000, '0, 0);
    send_cmd(pht_pkg::OP_LOOKUP, 16'h0000, 16'h0000, '0, 0);
    send_cmd(pht_pkg::OP_INSERT, 16'hFFFF, 16'h0000, '0, 0);
    send_cmd(pht_pkg::OP_INSERT, 16'h0000, 16'hFFFF, '0, 0);
    send_cmd(pht_pkg::OP_SET_VALUE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send_cmd(pht_pkg::OP_SET_VALUE, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 0);
    send_cmd(pht_pkg::OP_SET_VALUE, 16'h0000, 16'h0000, 32'hA5A5_5A5A, 0);
    send_cmd(pht_pkg::OP_MARK_MOVED, 16'hFFFF, 16'h1234, '0, 0);
    send_cmd(pht_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000, '0, 0);
    send_cmd(pht_pkg::OP_INSERT, 16'h0000, 16'hFFFF, '0, 0);
    send_cmd(pht_pkg::OP_MARK_MOVED, 16'h0000, 16'h0000, '0, 0);
    send_cmd(pht_pkg::OP_BEGIN_UPD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send_cmd(pht_pkg::OP_LOOKUP, 16'h0000, 16'h0000, '0, 0);
    send_cmd(pht_pkg::OP_REMOVE, 16'h0000, 16'h0000, '0, 0);
    send_cmd(pht_pkg::OP_REMOVE, 16'h0000, 16'h0000, '0, 0);
    send_cmd(3'd6, 16'h1111, 16'h2222, 32'h1, 0);
    send_cmd(3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);

    // Back-to-back inserts while out_tready is held off, so the block stalls its input.
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < N_FILL; i++)
        send_cmd(pht_pkg::OP_INSERT, 16'(i), 16'(i * 7 + 3), '0, 1);
    join
    // Drain half of them again, exercising backward-shift repair in clusters.
    for (int i = 0; i < N_FILL; i += 2)
      send_cmd(pht_pkg::OP_REMOVE, 16'(i * 7 + 3), 16'(i), '0, 1);

    // Random traffic mostly over a small id pool so pairs hit, collide and recur.
    for (int n = 0; n < N_RANDOM; n++) begin
      a = pick_id();
      b = pick_id();
      sel = $urandom_range(0, 99);
      if (sel < 30) send_cmd(pht_pkg::OP_INSERT, a, b, 32'($urandom), 0);
      else if (sel < 50) send_cmd(pht_pkg::OP_LOOKUP, a, b, 32'($urandom), 0);
      else if (sel < 65) send_cmd(pht_pkg::OP_REMOVE, a, b, 32'($urandom), 0);
      else if (sel < 85) send_cmd(pht_pkg::OP_SET_VALUE, a, b, 32'($urandom), 0);
      else if (sel < 91) send_cmd(pht_pkg::OP_MARK_MOVED, a, b, 32'($urandom), 0);
      else if (sel < 96) send_cmd(pht_pkg::OP_BEGIN_UPD, a, b, 32'($urandom), 0);
      else send_cmd(3'($urandom_range(6, 7)), a, b, 32'($urandom), 0);
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
